[hdl/rbi_pkg.sv]
// Shared types, constants and result codes for the ray versus box intersector.
// No dependencies.
`default_nettype none
package rbi_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  // dividend is |diff| (COORD_W+1 bits) shifted up by FRAC_BITS
  localparam int NUM_W     = COORD_W + 1 + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [2:0][COORD_W-1:0]   vec3_t;

  localparam coord_t T_NONE = -(coord_t'(1) <<< FRAC_BITS);

  localparam logic [1:0] CLS_WITHIN = 2'd0;
  localparam logic [1:0] CLS_BELOW  = 2'd1;
  localparam logic [1:0] CLS_ABOVE  = 2'd2;

  localparam logic [1:0] KIND_MISS   = 2'd0;
  localparam logic [1:0] KIND_HIT    = 2'd1;
  localparam logic [1:0] KIND_INSIDE = 2'd2;

  localparam logic [2:0] FACE_NONE = 3'd0;
  localparam logic [2:0] FACE_ALL  = 3'd1;
  localparam logic [2:0] FACE_XN   = 3'd2;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  typedef struct packed {
    logic            in_box;
    logic [2:0][1:0] cls;
    logic [2:0]      use_div;
    logic [2:0]      neg;
    vec3_t           org;
    vec3_t           dir;
    vec3_t           cand;
  } side_t;

  typedef struct packed {
    logic       in_box;
    logic       miss;
    logic [1:0] w;
    logic       above;
    coord_t     tw;
    vec3_t      org;
    vec3_t      dir;
    vec3_t      cand;
  } sel_t;
endpackage
`default_nettype wire

[hdl/rbi_classify.sv]
// Input stage: slab classification per axis and divider operand setup.
// Uses rbi_pkg.
`default_nettype none
module rbi_classify (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             en,
  input  wire                             vld_in,
  input  wire rbi_pkg::vec3_t             org,
  input  wire rbi_pkg::vec3_t             dir,
  input  wire rbi_pkg::vec3_t             box_lo,
  input  wire rbi_pkg::vec3_t             box_hi,
  output logic                            vld_r,
  output rbi_pkg::side_t                  side_r,
  output logic [2:0][rbi_pkg::NUM_W-1:0]  num_r,
  output logic [2:0][rbi_pkg::COORD_W-1:0] den_r
);
  rbi_pkg::side_t                   side_nxt;
  logic [2:0][rbi_pkg::NUM_W-1:0]   num_nxt;
  logic [2:0][rbi_pkg::COORD_W-1:0] den_nxt;
  logic [2:0]                       below, above;
  logic signed [rbi_pkg::COORD_W:0] diff [3];
  logic [rbi_pkg::COORD_W:0]        absd [3];

  always_comb begin
    side_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      below[i] = $signed(org[i]) < $signed(box_lo[i]);
      above[i] = !below[i] && ($signed(org[i]) > $signed(box_hi[i]));
      side_nxt.org[i]  = org[i];
      side_nxt.dir[i]  = dir[i];
      side_nxt.cand[i] = below[i] ? box_lo[i] : (above[i] ? box_hi[i] : '0);
      side_nxt.cls[i]  = below[i] ? rbi_pkg::CLS_BELOW :
                         (above[i] ? rbi_pkg::CLS_ABOVE : rbi_pkg::CLS_WITHIN);
      diff[i] = $signed({side_nxt.cand[i][rbi_pkg::COORD_W-1], side_nxt.cand[i]})
              - $signed({org[i][rbi_pkg::COORD_W-1], org[i]});
      absd[i] = diff[i][rbi_pkg::COORD_W] ? -diff[i] : diff[i];
      num_nxt[i] = {absd[i], {rbi_pkg::FRAC_BITS{1'b0}}};
      den_nxt[i] = dir[i][rbi_pkg::COORD_W-1] ? -dir[i] : dir[i];
      side_nxt.neg[i]     = diff[i][rbi_pkg::COORD_W] ^ dir[i][rbi_pkg::COORD_W-1];
      side_nxt.use_div[i] = (below[i] || above[i]) && (dir[i] != '0);
    end
    side_nxt.in_box = !(|below) && !(|above);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/rbi_div_pipe.sv]
// Unsigned restoring divider, one quotient bit per pipeline stage.
// Uses rbi_pkg for operand widths.
`default_nettype none
module rbi_div_pipe (
  input  wire                          clk,
  input  wire                          en,
  input  wire [rbi_pkg::NUM_W-1:0]     num,
  input  wire [rbi_pkg::COORD_W-1:0]   den,
  output logic [rbi_pkg::NUM_W-1:0]    quo
);
  localparam int N = rbi_pkg::DIV_STEPS;
  localparam int W = rbi_pkg::COORD_W;

  logic [W-1:0]              rem_s [0:N];
  logic [rbi_pkg::NUM_W-1:0] num_s [0:N];
  logic [rbi_pkg::NUM_W-1:0] quo_s [0:N];
  logic [W-1:0]              den_s [0:N];

  assign rem_s[0] = '0;
  assign num_s[0] = num;
  assign quo_s[0] = '0;
  assign den_s[0] = den;
  assign quo      = quo_s[N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W:0]   trial;
    logic         qbit;
    logic [W-1:0] rem_nxt;
    always_comb begin
      trial   = {rem_s[k], num_s[k][rbi_pkg::NUM_W-1]};
      qbit    = trial >= {1'b0, den_s[k]};
      rem_nxt = qbit ? W'(trial - {1'b0, den_s[k]}) : trial[W-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= rem_nxt;
        num_s[k+1] <= {num_s[k][rbi_pkg::NUM_W-2:0], 1'b0};
        quo_s[k+1] <= {quo_s[k][rbi_pkg::NUM_W-2:0], qbit};
        den_s[k+1] <= den_s[k];
      end
    end
  end
endmodule
`default_nettype wire

[hdl/rbi_select.sv]
// Quotient sign and saturation, then the largest-t axis pick.
// Uses rbi_pkg.
`default_nettype none
module rbi_select (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            en,
  input  wire                            vld_in,
  input  wire rbi_pkg::side_t            side,
  input  wire [2:0][rbi_pkg::NUM_W-1:0]  quo,
  output logic                           vld_r,
  output rbi_pkg::sel_t                  sel_r
);
  localparam int W = rbi_pkg::COORD_W;
  rbi_pkg::sel_t  sel_nxt;
  rbi_pkg::coord_t t [3];
  logic [1:0]     w01;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!side.use_div[i]) begin
        t[i] = rbi_pkg::T_NONE;
      end else if (side.neg[i]) begin
        if ((quo[i][rbi_pkg::NUM_W-1:W] != '0) || (quo[i][W-1] && (quo[i][W-2:0] != '0)))
          t[i] = {1'b1, {(W-1){1'b0}}};
        else
          t[i] = -quo[i][W-1:0];
      end else begin
        if (quo[i][rbi_pkg::NUM_W-1:W-1] != '0)
          t[i] = {1'b0, {(W-1){1'b1}}};
        else
          t[i] = quo[i][W-1:0];
      end
    end
    // lowest axis wins a tie
    w01 = (t[0] < t[1]) ? 2'd1 : 2'd0;
    sel_nxt.w      = (t[w01] < t[2]) ? 2'd2 : w01;
    sel_nxt.tw     = t[sel_nxt.w];
    sel_nxt.miss   = sel_nxt.tw < 0;
    sel_nxt.above  = side.cls[sel_nxt.w] == rbi_pkg::CLS_ABOVE;
    sel_nxt.in_box = side.in_box;
    sel_nxt.org    = side.org;
    sel_nxt.dir    = side.dir;
    sel_nxt.cand   = side.cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= sel_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/rbi_resolve.sv]
// Hit point products, box range check and result formatting (two stages).
// Uses rbi_pkg.
`default_nettype none
module rbi_resolve (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 vld_in,
  input  wire rbi_pkg::sel_t  sel,
  input  wire rbi_pkg::vec3_t box_lo,
  input  wire rbi_pkg::vec3_t box_hi,
  output logic                vld_r,
  output logic [1:0]          kind_r,
  output logic [2:0]          face_r,
  output rbi_pkg::vec3_t      pt_r
);
  localparam int W = rbi_pkg::COORD_W;
  logic                 s1_vld_r;
  rbi_pkg::sel_t        s1_r;
  logic signed [2*W-1:0] prod_r [3];

  logic signed [2*W-1:0] pt_full [3];
  logic [2:0]            ok;
  logic                  hit;
  logic [1:0]            kind_nxt;
  logic [2:0]            face_nxt;
  rbi_pkg::vec3_t        pt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_in;
      vld_r    <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= sel;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= $signed(sel.tw) * $signed(sel.dir[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // arithmetic shift floors, as required
      pt_full[i] = (2*W)'($signed(s1_r.org[i])) + (prod_r[i] >>> rbi_pkg::FRAC_BITS);
      ok[i] = (s1_r.w == 2'(i)) ||
              ((pt_full[i] >= (2*W)'($signed(box_lo[i]))) &&
               (pt_full[i] <= (2*W)'($signed(box_hi[i]))));
    end
    hit = !s1_r.miss && (&ok);
    if (s1_r.in_box) begin
      kind_nxt = rbi_pkg::KIND_INSIDE;
      face_nxt = rbi_pkg::FACE_ALL;
      pt_nxt   = s1_r.org;
    end else if (hit) begin
      kind_nxt = rbi_pkg::KIND_HIT;
      face_nxt = rbi_pkg::FACE_XN + {s1_r.w, 1'b0} + {2'b00, s1_r.above};
      for (int i = 0; i < 3; i++) begin
        pt_nxt[i] = (s1_r.w == 2'(i)) ? s1_r.cand[i] : pt_full[i][W-1:0];
      end
    end else begin
      kind_nxt = rbi_pkg::KIND_MISS;
      face_nxt = rbi_pkg::FACE_NONE;
      pt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= kind_nxt;
      face_r <= face_nxt;
      pt_r   <= pt_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/ray_box_intersect_top.sv]
// Ray versus axis-aligned box intersector, top level: config registers,
// pipeline control and sideband delay line. Uses rbi_pkg and all rbi_* modules.
//
// Usage:
//  - Box corners are written over the APB port (min x,y,z at 0x00..0x08,
//    max x,y,z at 0x0C..0x14), only while no ray is in flight. Reset sets 0.
//  - Input channel in_*: one ray per transaction (origin, direction, Q16.16).
//  - Output channel out_*: one result per ray, in order: kind, face, point.
//  - Pipeline stages in order: classify, divider (one quotient bit per
//    stage of three parallel dividers), select, multiply, check.
//  - Throughput is one ray per cycle when not stalled; dividers fully pipelined.
//  - A stalled output freezes the whole pipeline and raises in_stall the
//    same cycle; nothing is dropped or repeated. Bubbles carry valid low.
//  - Reset (synchronous, active low) clears all valid bits and the box
//    registers; data registers are left as they are.
`default_nettype none
module ray_box_intersect_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_origin_x,
  input  wire  [31:0] in_origin_y,
  input  wire  [31:0] in_origin_z,
  input  wire  [31:0] in_dir_x,
  input  wire  [31:0] in_dir_y,
  input  wire  [31:0] in_dir_z,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_hit_kind,
  output logic [2:0]  out_hit_face,
  output logic [31:0] out_hit_x,
  output logic [31:0] out_hit_y,
  output logic [31:0] out_hit_z
);
  localparam int N = rbi_pkg::DIV_STEPS;

  rbi_pkg::vec3_t box_lo_r, box_hi_r;
  logic [2:0]     reg_idx;
  logic           advance;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_lo_r <= '0;
      box_hi_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        rbi_pkg::REG_MIN_X: box_lo_r[0] <= pwdata;
        rbi_pkg::REG_MIN_Y: box_lo_r[1] <= pwdata;
        rbi_pkg::REG_MIN_Z: box_lo_r[2] <= pwdata;
        rbi_pkg::REG_MAX_X: box_hi_r[0] <= pwdata;
        rbi_pkg::REG_MAX_Y: box_hi_r[1] <= pwdata;
        rbi_pkg::REG_MAX_Z: box_hi_r[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rbi_pkg::REG_MIN_X: prdata = box_lo_r[0];
      rbi_pkg::REG_MIN_Y: prdata = box_lo_r[1];
      rbi_pkg::REG_MIN_Z: prdata = box_lo_r[2];
      rbi_pkg::REG_MAX_X: prdata = box_hi_r[0];
      rbi_pkg::REG_MAX_Y: prdata = box_hi_r[1];
      rbi_pkg::REG_MAX_Z: prdata = box_hi_r[2];
      default:            prdata = '0;
    endcase
  end

  // whole pipeline moves unless a finished result is held by the receiver
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  rbi_pkg::vec3_t                   in_org, in_dir;
  logic                             cls_vld;
  rbi_pkg::side_t                   cls_side;
  logic [2:0][rbi_pkg::NUM_W-1:0]   div_num, div_quo;
  logic [2:0][rbi_pkg::COORD_W-1:0] div_den;

  assign in_org = {in_origin_z, in_origin_y, in_origin_x};
  assign in_dir = {in_dir_z, in_dir_y, in_dir_x};

  rbi_classify u_classify (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .vld_in (in_valid),
    .org    (in_org),
    .dir    (in_dir),
    .box_lo (box_lo_r),
    .box_hi (box_hi_r),
    .vld_r  (cls_vld),
    .side_r (cls_side),
    .num_r  (div_num),
    .den_r  (div_den)
  );

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbi_div_pipe u_div (
      .clk (clk),
      .en  (advance),
      .num (div_num[a]),
      .den (div_den[a]),
      .quo (div_quo[a])
    );
  end

  // sideband travels alongside the divider stages
  logic           vld_s  [0:N];
  rbi_pkg::side_t side_s [0:N];
  assign vld_s[0]  = cls_vld;
  assign side_s[0] = cls_side;

  for (genvar k = 0; k < N; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s[k+1] <= 1'b0;
      end else if (advance) begin
        vld_s[k+1] <= vld_s[k];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        side_s[k+1] <= side_s[k];
      end
    end
  end

  logic          sel_vld;
  rbi_pkg::sel_t sel;

  rbi_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .vld_in (vld_s[N]),
    .side   (side_s[N]),
    .quo    (div_quo),
    .vld_r  (sel_vld),
    .sel_r  (sel)
  );

  rbi_pkg::vec3_t out_pt;

  rbi_resolve u_resolve (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .vld_in (sel_vld),
    .sel    (sel),
    .box_lo (box_lo_r),
    .box_hi (box_hi_r),
    .vld_r  (out_valid),
    .kind_r (out_hit_kind),
    .face_r (out_hit_face),
    .pt_r   (out_pt)
  );

  assign out_hit_x = out_pt[0];
  assign out_hit_y = out_pt[1];
  assign out_hit_z = out_pt[2];

  a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output hold");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit_kind == rbi_pkg::KIND_MISS) |->
      (out_hit_face == rbi_pkg::FACE_NONE) && (out_hit_x == '0) &&
      (out_hit_y == '0) && (out_hit_z == '0))
    else $error("miss result carries a point or face");

  a_inside_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit_kind == rbi_pkg::KIND_INSIDE) |->
      (out_hit_face == rbi_pkg::FACE_ALL))
    else $error("inside result without all-faces code");

  a_hit_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit_kind == rbi_pkg::KIND_HIT) |->
      (out_hit_face >= rbi_pkg::FACE_XN))
    else $error("hit result without a face");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(sel_vld) && $stable(cls_vld))
    else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
